[rtl/gfs_pkg.sv]
// ----------------------------------------------------------------------------
// gfs_pkg
// Shared constants for the Gaussian FIR smoother.
// ----------------------------------------------------------------------------
package gfs_pkg;

  localparam int GFS_MAX_TAPS   = 64;
  localparam int GFS_COEF_SHIFT = 14;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int INDEX_W  = 6;
  localparam int TAPCFG_W = 7;

  // tuser command codes
  localparam logic CMD_COEF   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

endpackage

[rtl/gaussian_fir_smoother_core.sv]
// ----------------------------------------------------------------------------
// gaussian_fir_smoother_core
// Symmetric Gaussian FIR smoother with one shared folded multiply-accumulate.
//
//   Channel  Dir  Payload                                   Transfer
//   s_axis   in   tuser=command, tdata=index/value/sample,  tvalid & tready
//                 tlast=last sample
//   m_axis   out  tdata=filtered, tlast=last of record      tvalid & tready
//   cfg      in   wdata=tap_count                           we
//
// Coefficient writes are taken in StIdle. Each sample is taken in StIdle, then each
// output is accumulated over the taps in use, one tap per cycle on the shared
// multiplier; StCheck steps past each window position that yields no output.
// Samples sit in a 2*MaxTaps-1 entry ring, read twice per tap via two RAM copies.
// Reset clears control state only; no clearing pass.
// s_axis is ready only when idle; a full output register holds StOut until m_axis takes it.
// ----------------------------------------------------------------------------
module gaussian_fir_smoother_core
  import gfs_pkg::*;
#(
  parameter int MaxTaps   = GFS_MAX_TAPS,
  parameter int CoefShift = GFS_COEF_SHIFT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TAPCFG_W-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [5:0] coef_index, [21:6] coef_value, [37:22] sample, [39:38] zero
  input  logic [39:0]         s_axis_tdata_i,
  input  logic                s_axis_tlast_i,
  // [0] command
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [15:0] filtered
  output logic [SAMPLE_W-1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o
);

  localparam int WinDepth = 2 * MaxTaps - 1;
  localparam int WinAw    = $clog2(WinDepth);
  localparam int WinCw    = $clog2(WinDepth + 1);
  localparam int KW       = WinCw + 1;
  localparam int TapW     = $clog2(MaxTaps + 1);
  localparam int CoefAw   = $clog2(MaxTaps);
  localparam int ShiftW   = CoefShift + 1;
  localparam int AccW     = ShiftW + SAMPLE_W;
  localparam int PairW    = SAMPLE_W + 1;
  localparam int ProdW    = PairW + COEF_W;

  typedef enum logic [2:0] {StIdle, StCheck, StMac, StDrain, StOut} state_e;

  state_e               state_q, state_d;
  logic [TAPCFG_W-1:0]  tapcfg_q;
  logic                 in_rec_q, in_rec_d;
  logic [WinCw-1:0]     seen_q, seen_d;
  logic [WinAw-1:0]     wptr_q, wptr_d;
  logic [SAMPLE_W-1:0]  first_q, first_d;
  logic                 last_q, last_d;
  logic [TapW-1:0]      taps_q, taps_d;
  logic [TapW-1:0]      flush_q, flush_d;
  logic [TapW-1:0]      tap_q, tap_d;
  logic                 p1_vld_q, p1_vld_d;
  logic                 p1_sel1_q, p1_sel1_d;
  logic                 p1_sel2_q, p1_sel2_d;
  logic                 p1_ctr_q, p1_ctr_d;
  logic                 p2_vld_q, p2_vld_d;
  logic [AccW-1:0]      prod_q, prod_d;
  logic [AccW-1:0]      acc_q, acc_d;
  logic                 out_vld_q, out_vld_d;
  logic [SAMPLE_W-1:0]  out_data_q, out_data_d;
  logic                 out_last_q, out_last_d;

  logic                 accept;
  logic [INDEX_W-1:0]   in_index;
  logic [COEF_W-1:0]    in_coef;
  logic [SAMPLE_W-1:0]  in_sample;
  logic [TapW-1:0]      taps_cfg;
  logic [WinAw-1:0]     wptr_nxt;
  logic                 coef_we;
  logic                 win_we;
  logic [KW-1:0]        k1, k2, r1, r2, a1, a2, fl_k, seen_k;
  logic [WinAw-1:0]     raddr1, raddr2;
  logic [SAMPLE_W-1:0]  win1_rdata, win2_rdata, s1, s2;
  logic [COEF_W-1:0]    coef_rdata;
  logic [PairW-1:0]     pair;
  logic [ProdW-1:0]     prod_full;
  logic                 more_flush;

  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign in_index  = s_axis_tdata_i[5:0];
  assign in_coef   = s_axis_tdata_i[21:6];
  assign in_sample = s_axis_tdata_i[37:22];

  always_comb begin
    if (tapcfg_q == '0) begin
      taps_cfg = TapW'(1);
    end else if (int'(tapcfg_q) > MaxTaps) begin
      taps_cfg = TapW'(MaxTaps);
    end else begin
      taps_cfg = TapW'(tapcfg_q);
    end
  end

  assign wptr_nxt = (wptr_q == WinAw'(WinDepth - 1)) ? '0 : wptr_q + 1'b1;

  // model window index -> ring age, with clamps at both record ends
  assign fl_k   = KW'(flush_q);
  assign seen_k = KW'(seen_q);
  assign k1     = KW'(taps_q) - KW'(1) - KW'(tap_q);
  assign k2     = KW'(taps_q) - KW'(1) + KW'(tap_q);
  assign r1     = (k1 >= fl_k) ? k1 - fl_k : '0;
  assign r2     = (k2 >= fl_k) ? k2 - fl_k : '0;
  assign a1     = (KW'(wptr_q) >= r1) ? KW'(wptr_q) - r1 : KW'(wptr_q) + KW'(WinDepth) - r1;
  assign a2     = (KW'(wptr_q) >= r2) ? KW'(wptr_q) - r2 : KW'(wptr_q) + KW'(WinDepth) - r2;
  assign raddr1 = a1[WinAw-1:0];
  assign raddr2 = a2[WinAw-1:0];

  assign s1        = p1_sel1_q ? first_q : win1_rdata;
  assign s2        = p1_ctr_q ? '0 : (p1_sel2_q ? first_q : win2_rdata);
  assign pair      = PairW'(s1) + PairW'(s2);
  assign prod_full = ProdW'(pair) * ProdW'(coef_rdata);

  assign more_flush = last_q && (flush_q < taps_q - 1'b1);

  always_comb begin
    state_d    = state_q;
    in_rec_d   = in_rec_q;
    seen_d     = seen_q;
    wptr_d     = wptr_q;
    first_d    = first_q;
    last_d     = last_q;
    taps_d     = taps_q;
    flush_d    = flush_q;
    tap_d      = tap_q;
    acc_d      = acc_q;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    coef_we    = 1'b0;
    win_we     = 1'b0;

    p1_vld_d  = (state_q == StMac);
    p1_sel1_d = (r1 >= seen_k);
    p1_sel2_d = (r2 >= seen_k);
    p1_ctr_d  = (tap_q == '0);
    p2_vld_d  = p1_vld_q;
    prod_d    = AccW'(prod_full);
    if (p2_vld_q) begin
      acc_d = acc_q + prod_q;
    end

    s_axis_tready_o = (state_q == StIdle);

    case (state_q)
      StIdle: begin
        if (accept) begin
          if (s_axis_tuser_i == CMD_COEF) begin
            coef_we = (int'(in_index) < MaxTaps);
          end else begin
            win_we  = 1'b1;
            wptr_d  = wptr_nxt;
            if (!in_rec_q) begin
              first_d = in_sample;
              seen_d  = WinCw'(1);
            end else if (seen_q != WinCw'(WinDepth)) begin
              seen_d = seen_q + 1'b1;
            end
            in_rec_d = !s_axis_tlast_i;
            last_d   = s_axis_tlast_i;
            flush_d  = '0;
            taps_d   = taps_cfg;
            state_d  = StCheck;
          end
        end
      end
      StCheck: begin
        if (seen_k + fl_k >= KW'(taps_q)) begin
          tap_d   = '0;
          acc_d   = '0;
          state_d = StMac;
        end else if (more_flush) begin
          flush_d = flush_q + 1'b1;
        end else begin
          state_d = StIdle;
        end
      end
      StMac: begin
        if (tap_q == taps_q - 1'b1) begin
          state_d = StDrain;
        end else begin
          tap_d = tap_q + 1'b1;
        end
      end
      StDrain: begin
        if (!p1_vld_q && !p2_vld_q) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d  = 1'b1;
          out_data_d = acc_q[ShiftW +: SAMPLE_W];
          out_last_d = last_q && (flush_q == taps_q - 1'b1);
          if (more_flush) begin
            flush_d = flush_q + 1'b1;
            state_d = StCheck;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      tapcfg_q  <= TAPCFG_W'(1);
      in_rec_q  <= 1'b0;
      seen_q    <= '0;
      wptr_q    <= '0;
      flush_q   <= '0;
      tap_q     <= '0;
      taps_q    <= TapW'(1);
      last_q    <= 1'b0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        tapcfg_q <= cfg_wdata_i;
      end
      in_rec_q  <= in_rec_d;
      seen_q    <= seen_d;
      wptr_q    <= wptr_d;
      flush_q   <= flush_d;
      tap_q     <= tap_d;
      taps_q    <= taps_d;
      last_q    <= last_d;
      p1_vld_q  <= p1_vld_d;
      p2_vld_q  <= p2_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q    <= first_d;
    p1_sel1_q  <= p1_sel1_d;
    p1_sel2_q  <= p1_sel2_d;
    p1_ctr_q   <= p1_ctr_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  gfs_ram #(
    .Width (COEF_W),
    .Depth (MaxTaps)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (CoefAw'(in_index)),
    .wdata_i (in_coef),
    .raddr_i (CoefAw'(tap_q)),
    .rdata_o (coef_rdata)
  );

  gfs_ram #(
    .Width (SAMPLE_W),
    .Depth (WinDepth)
  ) u_win_ram_a (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (wptr_nxt),
    .wdata_i (in_sample),
    .raddr_i (raddr1),
    .rdata_o (win1_rdata)
  );

  gfs_ram #(
    .Width (SAMPLE_W),
    .Depth (WinDepth)
  ) u_win_ram_b (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (wptr_nxt),
    .wdata_i (in_sample),
    .raddr_i (raddr2),
    .rdata_o (win2_rdata)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

[rtl/gfs_ram.sv]
// ----------------------------------------------------------------------------
// gfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gfs_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
